/* hw/rtl/assert_macros.svh */
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

/* hw/rtl/sha256_pkg.sv */
`timescale 1ns / 1ps
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } in_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_number;
        logic        last_word;
    } out_item_t;

    // Entry of the queue between the input channel and the round engine.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } cmd_t;

    localparam int QueueDepthDef = 4;

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos  = 6'd56;

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        rotr = (v >> n) | (v << (32 - n));
    endfunction

endpackage

/* hw/rtl/sha256_fifo.sv */
`timescale 1ns / 1ps
module sha256_fifo #(
    parameter int Depth = sha256_pkg::QueueDepthDef
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  sha256_pkg::cmd_t  wr_data,
    output logic              full,
    input  logic              pop,
    output sha256_pkg::cmd_t  rd_data,
    output logic              empty
);
    import sha256_pkg::*;
    `include "assert_macros.svh"

    localparam int Aw = (Depth > 1) ? $clog2(Depth) : 1;

    cmd_t           mem_reg [Depth];
    logic [Aw-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [Aw:0]    count_reg;

    assign full    = (count_reg == (Aw + 1)'(Depth));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    logic do_wr, do_rd;
    assign do_wr = push && !full;
    assign do_rd = pop && !empty;

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= (wr_ptr_reg == Aw'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd)
            begin
                rd_ptr_reg <= (rd_ptr_reg == Aw'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (Aw + 1)'(do_wr) - (Aw + 1)'(do_rd);
        end
    end

    `ASSERT_NEVER(a_count_range, clk, rst_n, count_reg > (Aw + 1)'(Depth), "fifo overfilled")
    `ASSERT_CLK(a_count_step, clk, rst_n, (do_wr && !do_rd) |=> !empty, "fifo lost write")
    `ASSERT_CLK(a_count_hold, clk, rst_n, (do_wr == do_rd) |=> $stable(count_reg), "count moved")
endmodule

/* hw/rtl/sha256_engine.sv */
`timescale 1ns / 1ps
module sha256_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cmd_valid,
    input  sha256_pkg::cmd_t      cmd,
    output logic                  cmd_pop,
    output logic                  empty,
    input  logic                  pop,
    output sha256_pkg::out_item_t result
);
    import sha256_pkg::*;
    `include "assert_macros.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_ROUND = 3'd2;
    localparam logic [2:0] S_ADD   = 3'd3;
    localparam logic [2:0] S_PAD   = 3'd4;
    localparam logic [2:0] S_OUT   = 3'd5;

    logic [2:0]   state_reg;
    logic [31:0]  h_reg [8];
    logic [31:0]  v_reg [8];
    logic [31:0]  w_reg [16];
    logic [511:0] blk_reg;
    logic [63:0]  bits_reg;
    logic [5:0]   rnd_reg;
    logic         final_reg;    // the block in flight is the last one
    logic         pad_two_reg;  // padding needs one more block after this
    logic [2:0]   wn_reg;

    // Block byte at index i sits at bits [511-8i -: 8].
    logic [5:0] pos;
    assign pos = bits_reg[8:3];

    // Round datapath.
    logic [31:0] w_t, x2, x15, s0, s1, t1, t2, ea, ee;
    assign x2  = w_reg[14];
    assign x15 = w_reg[1];
    assign s1  = rotr(x2, 17) ^ rotr(x2, 19) ^ (x2 >> 10);
    assign s0  = rotr(x15, 7) ^ rotr(x15, 18) ^ (x15 >> 3);
    assign w_t = w_reg[0];
    assign ee  = v_reg[4];
    assign ea  = v_reg[0];
    assign t1  = v_reg[7] + (rotr(ee, 6) ^ rotr(ee, 11) ^ rotr(ee, 25))
               + ((ee & v_reg[5]) ^ (~ee & v_reg[6])) + RoundK[rnd_reg] + w_t;
    assign t2  = (rotr(ea, 2) ^ rotr(ea, 13) ^ rotr(ea, 22))
               + ((ea & v_reg[1]) ^ (ea & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
    logic [31:0] w_new;
    assign w_new = s1 + w_reg[9] + s0 + w_reg[0];

    assign cmd_pop = (state_reg == S_IDLE) && cmd_valid;
    assign empty   = (state_reg != S_OUT);
    assign result.digest_word = h_reg[wn_reg];
    assign result.word_number = wn_reg;
    assign result.last_word   = (wn_reg == 3'd7);

    // Build padded block into blk_reg given the fill level.
    function automatic logic [511:0] pad_block(input logic [511:0] b, input logic [5:0] p,
                                               input logic [63:0] len, input logic with_len,
                                               input logic with_mark);
        logic [511:0] r;
        r = b;
        for (int i = 0; i < 64; i++)
        begin
            if (6'(i) >= p)
            begin
                r[511 - 8*i -: 8] = (with_mark && 6'(i) == p) ? PadByte : 8'h00;
            end
        end
        if (with_len)
        begin
            r[63:0] = len;
        end
        return r;
    endfunction

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && cmd_valid && cmd.byte_present)
        begin
            blk_reg[511 - 8*pos -: 8] <= cmd.data_byte;
        end
        if (state_reg == S_PAD)
        begin
            if (pad_two_reg && !final_reg)
            begin
                blk_reg <= pad_block(blk_reg, pos, bits_reg, 1'b0, 1'b1);
            end
            else if (pad_two_reg)
            begin
                // A message that ended on a full block still needs its mark
                // at byte zero; after a first pad block the mark is already out.
                blk_reg <= pad_block(blk_reg, 6'd0, bits_reg, 1'b1, pos == 6'd0);
            end
            else
            begin
                blk_reg <= pad_block(blk_reg, pos, bits_reg, 1'b1, 1'b1);
            end
        end
        if (state_reg == S_LOAD)
        begin
            for (int i = 0; i < 16; i++)
            begin
                w_reg[i] <= blk_reg[511 - 32*i -: 32];
            end
            for (int i = 0; i < 8; i++)
            begin
                v_reg[i] <= h_reg[i];
            end
        end
        if (state_reg == S_ROUND)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6];
            v_reg[6] <= v_reg[5];
            v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2];
            v_reg[2] <= v_reg[1];
            v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
    end

    // The rolling window shifts each round, so w_reg[0] is always W[t];
    // new words W[t+16] are computed into w_reg[15], as the standard schedule needs.

    logic [2:0] st_sel;
    assign st_sel = state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            for (int i = 0; i < 8; i++) h_reg[i] <= InitH[i];
            bits_reg    <= '0;
            rnd_reg     <= '0;
            final_reg   <= 1'b0;
            pad_two_reg <= 1'b0;
            wn_reg      <= '0;
        end
        else
        begin
            unique case (st_sel)
                S_IDLE:
                begin
                    if (cmd_valid)
                    begin
                        if (cmd.byte_present)
                        begin
                            bits_reg <= bits_reg + 64'd8;
                        end
                        if (cmd.byte_present && pos == 6'd63)
                        begin
                            final_reg <= 1'b0;
                            pad_two_reg <= cmd.end_of_message;
                            state_reg <= S_LOAD;
                        end
                        else if (cmd.end_of_message)
                        begin
                            // Fill after this byte decides one or two pad blocks.
                            pad_two_reg <= (cmd.byte_present ? pos + 6'd1 : pos) >= LenPos;
                            final_reg   <= 1'b0;
                            state_reg   <= S_PAD;
                        end
                    end
                end
                S_PAD:
                begin
                    final_reg <= !pad_two_reg || final_reg;
                    state_reg <= S_LOAD;
                end
                S_LOAD:  state_reg <= S_ROUND;
                S_ROUND:
                begin
                    rnd_reg <= rnd_reg + 6'd1;
                    if (rnd_reg == 6'd63) state_reg <= S_ADD;
                end
                S_ADD:
                begin
                    for (int i = 0; i < 8; i++) h_reg[i] <= h_reg[i] + v_reg[i];
                    if (final_reg)
                    begin
                        state_reg <= S_OUT;
                        wn_reg <= '0;
                    end
                    else if (pad_two_reg)
                    begin
                        // A full block ended the message, or first of two pads done.
                        final_reg <= 1'b1;
                        state_reg <= S_PAD;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_OUT:
                begin
                    if (pop)
                    begin
                        wn_reg <= wn_reg + 3'd1;
                        if (wn_reg == 3'd7)
                        begin
                            for (int i = 0; i < 8; i++) h_reg[i] <= InitH[i];
                            bits_reg <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    `ASSERT_CLK(a_out_hold, clk, rst_n,
        (state_reg == S_OUT && !pop) |=> (state_reg == S_OUT), "digest dropped")
    `ASSERT_CLK(a_round_wrap, clk, rst_n,
        (state_reg == S_ROUND && rnd_reg == 6'd63) |=> (state_reg == S_ADD), "round count slip")
    `ASSERT_NEVER(a_rnd_idle, clk, rst_n,
        (state_reg == S_IDLE && rnd_reg != 6'd0), "round count not home")
    `ASSERT_NEVER(a_pop_busy, clk, rst_n,
        cmd_pop && state_reg != S_IDLE, "command taken while busy")
endmodule

/* hw/rtl/sha256_message_hasher_top.sv */
`timescale 1ns / 1ps
// Channel   | handshake      | payload
// input     | push / full    | in_item  (data_byte, byte_present, end_of_message)
// result    | pop / empty    | out_item (digest_word, word_number, last_word)
//
// A byte item is taken by the engine while it is idle; the 64th byte of a block
// starts the load, round and add states, bound by the single round unit, and
// items that come meanwhile wait in the input queue.
// End of message adds one or two padding blocks.
// Reset restores the initial hash value and empties the input queue.
// A held digest stalls the engine; the input queue keeps taking items until full.
module sha256_message_hasher_top #(
    parameter int QueueDepth = sha256_pkg::QueueDepthDef
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  sha256_pkg::in_item_t  in_item,
    output logic                  full,
    input  logic                  pop,
    output logic                  empty,
    output sha256_pkg::out_item_t out_item
);
    import sha256_pkg::*;

    // Items with neither byte nor end do nothing, so they are dropped here.
    cmd_t cmd_in, cmd_out;
    logic q_empty, q_pop, q_full;

    assign cmd_in.data_byte      = in_item.data_byte;
    assign cmd_in.byte_present   = in_item.byte_present;
    assign cmd_in.end_of_message = in_item.end_of_message;
    assign full = q_full;

    sha256_fifo #(.Depth(QueueDepth)) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push && (in_item.byte_present || in_item.end_of_message)),
        .wr_data (cmd_in),
        .full    (q_full),
        .pop     (q_pop),
        .rd_data (cmd_out),
        .empty   (q_empty)
    );

    sha256_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (!q_empty),
        .cmd       (cmd_out),
        .cmd_pop   (q_pop),
        .empty     (empty),
        .pop       (pop),
        .result    (out_item)
    );
endmodule

/* tb/sv/tb_sha256_message_hasher_top.sv */
`timescale 1ns / 1ps
module tb_sha256_message_hasher_top;
    import sha256_pkg::*;

    // Longest quiet stretch with nothing accepted before the run is abandoned.
    localparam int StallLimit = 20000;

    // Predicts the digest words of the hasher from the bytes it accepts and
    // holds them in order until the block delivers them.
    class digest_scoreboard;
        logic [31:0] chain [8];
        logic [7:0]  blk [64];
        logic [63:0] nbits;
        out_item_t   pending_words[$];
        int          errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                chain[i] = InitH[i];
            nbits = '0;
        endfunction

        function logic [31:0] ror(logic [31:0] v, int n);
            return (v >> n) | (v << (32 - n));
        endfunction

        function void compress();
            logic [31:0] w [16];
            logic [31:0] v [8];
            logic [31:0] x2, x15, wt, t1, t2;
            for (int t = 0; t < 16; t++)
                w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
            for (int i = 0; i < 8; i++)
                v[i] = chain[i];
            for (int t = 0; t < 64; t++)
            begin
                if (t < 16)
                    wt = w[t];
                else
                begin
                    x2  = w[(t - 2) & 15];
                    x15 = w[(t - 15) & 15];
                    wt = (ror(x2, 17) ^ ror(x2, 19) ^ (x2 >> 10)) + w[(t - 7) & 15]
                        + (ror(x15, 7) ^ ror(x15, 18) ^ (x15 >> 3)) + w[t & 15];
                    w[t & 15] = wt;
                end
                t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
                    + ((v[4] & v[5]) ^ (~v[4] & v[6])) + RoundK[t] + wt;
                t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
                    + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                for (int i = 7; i > 0; i--)
                    v[i] = v[i - 1];
                v[4] = v[4] + t1;
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += v[i];
        endfunction

        function void note_input(in_item_t it);
            int pos;
            out_item_t o;
            if (it.byte_present)
            begin
                pos = nbits[8:3];
                blk[pos] = it.data_byte;
                nbits += 64'd8;
                if (pos == 63)
                    compress();
            end
            if (!it.end_of_message)
                return;
            pos = nbits[8:3];
            blk[pos] = PadByte;
            pos++;
            if (pos > 56)
            begin
                while (pos < 64)
                begin
                    blk[pos] = 8'h00;
                    pos++;
                end
                compress();
                pos = 0;
            end
            while (pos < 56)
            begin
                blk[pos] = 8'h00;
                pos++;
            end
            for (int i = 0; i < 8; i++)
                blk[56 + i] = nbits[8*(7-i) +: 8];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                o.digest_word = chain[i];
                o.word_number = i[2:0];
                o.last_word   = (i == 7);
                pending_words.push_back(o);
            end
            restart();
        endfunction

        function void check_result(out_item_t got);
            out_item_t want;
            if (pending_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual %h", $time, got);
                errors++;
                return;
            end
            want = pending_words.pop_front();
            if (got.digest_word !== want.digest_word)
            begin
                $display("%0t: digest_word mismatch, expected %h, actual %h",
                    $time, want.digest_word, got.digest_word);
                errors++;
            end
            if (got.word_number !== want.word_number)
            begin
                $display("%0t: word_number mismatch, expected %0d, actual %0d",
                    $time, want.word_number, got.word_number);
                errors++;
            end
            if (got.last_word !== want.last_word)
            begin
                $display("%0t: last_word mismatch, expected %b, actual %b",
                    $time, want.last_word, got.last_word);
                errors++;
            end
        endfunction
    endclass

    logic      clk;
    logic      rst_n;
    logic      push;
    in_item_t  in_item;
    logic      full;
    logic      pop;
    logic      empty;
    out_item_t out_item;

    digest_scoreboard sb;
    // Idling on both sides stops once this is set, near the end of the run.
    bit steady;
    // While this is set the receiver holds off so the input queue backs up.
    bit hold_results;
    int quiet_cycles;

    sha256_message_hasher_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_item  (in_item),
        .full     (full),
        .pop      (pop),
        .empty    (empty),
        .out_item (out_item)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Offers one item at the falling edge and holds it until it is taken.
    // A random idle burst may come before it while idling is on.
    task automatic send_item(input logic [7:0] b, input logic present, input logic last);
        if (!steady && $urandom_range(0, 5) == 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        push <= 1'b1;
        in_item.data_byte      <= b;
        in_item.byte_present   <= present;
        in_item.end_of_message <= last;
        @(posedge clk);
        while (full)
            @(posedge clk);
        sb.note_input(in_item);
        @(negedge clk);
    endtask

    // Sends a whole message of n random bytes, closed by an end marker that
    // either carries the last byte or stands alone without one.
    task automatic send_message(input int n, input bit end_alone);
        for (int i = 0; i < n; i++)
            send_item(8'($urandom_range(0, 255)), 1'b1, (i == n - 1) && !end_alone);
        if (end_alone || n == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Receiver: pops at random, with idle bursts, and sits out a long
    // stretch whenever hold_results is raised.
    initial
    begin
        pop = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_results)
                pop <= 1'b0;
            else if (!steady && $urandom_range(0, 7) == 0)
            begin
                pop <= 1'b0;
                repeat ($urandom_range(1, 5) - 1) @(negedge clk);
            end
            else
                pop <= 1'b1;
        end
    end

    // Results are checked as they are accepted at the rising edge.
    always @(posedge clk)
        if (rst_n && pop && !empty)
            sb.check_result(out_item);

    // Watchdog: counts cycles in which neither side moves an item.
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= StallLimit)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // Holds the receiver off for a long stretch while messages keep coming.
    task automatic long_hold();
        hold_results = 1'b1;
        repeat (3000) @(negedge clk);
        hold_results = 1'b0;
    endtask

    initial
    begin
        int n;
        sb = new();
        steady = 1'b0;
        hold_results = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_item = '0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part: the empty message, an item that does nothing, byte
        // extremes, and message lengths around the padding boundaries.
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hff, 1'b0, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h55, 1'b1, 1'b0);
        send_item(8'haa, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_message(3, 1'b0);
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);

        // Random part, with the long receiver hold running alongside once.
        fork
            long_hold();
            for (int m = 0; m < 4; m++)
                send_message($urandom_range(0, 10), 1'($urandom_range(0, 1)));
        join
        for (int m = 0; m < 8; m++)
        begin
            if (m == 6)
                steady = 1'b1;
            case ($urandom_range(0, 9))
                0: n = $urandom_range(54, 66);
                1: n = $urandom_range(100, 130);
                default: n = $urandom_range(0, 12);
            endcase
            // Occasional stray items that carry nothing.
            if ($urandom_range(0, 4) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            send_message(n, $urandom_range(0, 2) == 0);
        end
        push <= 1'b0;

        while (sb.pending_words.size() != 0)
            @(negedge clk);
        // The block could still emit a stray word after the last one expected.
        repeat (300) @(negedge clk);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
